// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the block cache RTL.
// Included by files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge, off while reset is asserted
`define LWBC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be true
`define LWBC_NEVER(label, cond, msg) \
  `LWBC_ASSERT(label, !(cond), msg)

`endif

// ----- rtl/core/lwbc_pkg.sv -----
// Shared types and constants of the LRU write-back block cache.
// No dependencies; used by the controller, the datapath and the top level.
package lwbc_pkg;

  localparam int BLKNUM_W = 36;
  localparam int CFG_W    = 5;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_QUERY = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic load_item;
    logic lookup;
    logic touch;
    logic rd_issue;
    logic res_miss;
    logic res_full;
    logic res_flag;
    logic res_rdata;
    logic clr_dirty;
    logic scan_clr;
    logic scan_step;
    logic drop_clean;
    logic alloc;
    logic clr_step;
    logic wr_byte;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  last;
    logic  hit;
    logic  free_found;
    logic  clean_found;
    logic  scan_last;
    logic  clr_last;
    logic  over_max;
  } stat_t;

endpackage

// ----- rtl/core/lwbc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lwbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/lwbc_ctrl.sv -----
// Sequencer of the block cache: walks lookup, allocation, block clear,
// trim scans and result handoff. Depends on lwbc_pkg.
module lwbc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output lwbc_pkg::cmd_t  cmd,
  input  lwbc_pkg::stat_t stat
);

  typedef enum logic [3:0] {
    S_IDLE, S_LOOK, S_DISP, S_SCAN, S_ADEC, S_ALLOC, S_CLEAR, S_WRITE,
    S_TRIM, S_TSCAN, S_TDEC, S_RDCAP, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.lookup = 1'b1;
        state_nxt  = S_DISP;
      end
      S_DISP: begin
        unique case (stat.func)
          lwbc_pkg::FUNC_WRITE: begin
            if (stat.hit) begin
              cmd.touch = 1'b1;
              state_nxt = S_WRITE;
            end else begin
              cmd.scan_clr = 1'b1;
              state_nxt    = S_SCAN;
            end
          end
          lwbc_pkg::FUNC_READ: begin
            if (stat.hit) begin
              cmd.touch    = 1'b1;
              cmd.rd_issue = 1'b1;
              state_nxt    = S_RDCAP;
            end else begin
              cmd.res_miss = 1'b1;
              state_nxt    = S_DONE;
            end
          end
          lwbc_pkg::FUNC_QUERY: begin
            cmd.res_flag = stat.hit;
            state_nxt    = S_DONE;
          end
          lwbc_pkg::FUNC_CLEAR: begin
            cmd.clr_dirty = stat.hit;
            state_nxt     = S_DONE;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_ADEC;
        end
      end
      S_ADEC: begin
        priority if (stat.free_found) begin
          cmd.alloc = 1'b1;
          state_nxt = S_CLEAR;
        end else if (stat.clean_found) begin
          // make room: evict the least recent clean block, then allocate there
          cmd.drop_clean = 1'b1;
          state_nxt      = S_ALLOC;
        end else begin
          cmd.res_full = 1'b1;
          state_nxt    = S_TRIM;
        end
      end
      S_ALLOC: begin
        cmd.alloc = 1'b1;
        state_nxt = S_CLEAR;
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.wr_byte = 1'b1;
        state_nxt   = S_TRIM;
      end
      S_TRIM: begin
        if (stat.last && stat.over_max) begin
          cmd.scan_clr = 1'b1;
          state_nxt    = S_TSCAN;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_TSCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_TDEC;
        end
      end
      S_TDEC: begin
        if (stat.clean_found) begin
          cmd.drop_clean = 1'b1;
          state_nxt      = S_TRIM;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_RDCAP: begin
        cmd.res_rdata = 1'b1;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/core/lwbc_dp.sv -----
// Datapath of the block cache: item latch, slot table with LRU ranks, slot scan,
// block clear counter, byte RAM and result/output registers.
// Depends on lwbc_pkg and lwbc_ram.
module lwbc_dp #(
  parameter int BLOCK_BYTES = 4096,
  parameter int NUM_SLOTS   = 16,
  parameter int ADDR_BITS   = 48
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lwbc_pkg::cmd_t                cmd,
  output lwbc_pkg::stat_t               stat,
  input  logic [1:0]                    in_func,
  input  logic [ADDR_BITS-1:0]          in_addr,
  input  logic [lwbc_pkg::BYTE_W-1:0]   in_wbyte,
  input  logic                          in_last,
  input  logic [lwbc_pkg::BLKNUM_W-1:0] in_bnum,
  input  logic                          cfg_we,
  input  logic [lwbc_pkg::CFG_W-1:0]    cfg_wdata,
  output logic [lwbc_pkg::STATUS_W-1:0] out_status,
  output logic [lwbc_pkg::BYTE_W-1:0]   out_rbyte,
  output logic                          out_dflag,
  output logic [$clog2(NUM_SLOTS+1)-1:0] out_count
);

  localparam int OFF_W = $clog2(BLOCK_BYTES);
  localparam int SL_W  = $clog2(NUM_SLOTS);
  localparam int TAG_W = ADDR_BITS - OFF_W;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int KW    = (TAG_W > lwbc_pkg::BLKNUM_W) ? TAG_W : lwbc_pkg::BLKNUM_W;
  localparam int MW    = (CNT_W > lwbc_pkg::CFG_W) ? CNT_W : lwbc_pkg::CFG_W;
  localparam int DEPTH = NUM_SLOTS * BLOCK_BYTES;

  // latched item
  lwbc_pkg::func_t               func_r;
  logic [ADDR_BITS-1:0]          addr_r;
  logic [lwbc_pkg::BYTE_W-1:0]   wbyte_r;
  logic                          last_r;
  logic [lwbc_pkg::BLKNUM_W-1:0] bnum_r;

  // slot table
  logic [TAG_W-1:0]     tag_r [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] valid_r;
  logic [NUM_SLOTS-1:0] dirty_r;
  logic [SL_W-1:0]      rank_r [NUM_SLOTS];
  logic [CNT_W-1:0]     cnt_r;
  logic [lwbc_pkg::CFG_W-1:0] max_r;

  logic            hit_r;
  logic [SL_W-1:0] hit_idx_r;
  logic [SL_W-1:0] scan_idx_r;
  logic            free_found_r, clean_found_r;
  logic [SL_W-1:0] free_idx_r, clean_idx_r, clean_rank_r;
  logic [OFF_W-1:0] clr_cnt_r;

  logic [lwbc_pkg::STATUS_W-1:0] res_status_r;
  logic [lwbc_pkg::BYTE_W-1:0]   res_rbyte_r;
  logic                          res_dflag_r;

  logic [KW-1:0]   key;
  logic            match_any;
  logic [SL_W-1:0] match_idx;
  logic [SL_W-1:0] hit_rank, drop_rank, alloc_idx;
  logic [OFF_W-1:0] off;
  logic [lwbc_pkg::BYTE_W-1:0] ram_q;

  assign off       = addr_r[OFF_W-1:0];
  assign hit_rank  = rank_r[hit_idx_r];
  assign drop_rank = rank_r[clean_idx_r];
  assign alloc_idx = free_found_r ? free_idx_r : clean_idx_r;

  // tags of valid slots are unique, so an OR of matching indexes is the hit index
  always_comb begin
    if (func_r == lwbc_pkg::FUNC_WRITE || func_r == lwbc_pkg::FUNC_READ) begin
      key = KW'(addr_r[ADDR_BITS-1:OFF_W]);
    end else begin
      key = KW'(bnum_r);
    end
    match_any = 1'b0;
    match_idx = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (valid_r[i] && KW'(tag_r[i]) == key) begin
        match_any = 1'b1;
        match_idx = match_idx | SL_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      func_r  <= lwbc_pkg::func_t'(in_func);
      addr_r  <= in_addr;
      wbyte_r <= in_wbyte;
      last_r  <= in_last;
      bnum_r  <= in_bnum;
    end
    if (cmd.alloc) begin
      tag_r[alloc_idx] <= addr_r[ADDR_BITS-1:OFF_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      dirty_r <= '0;
      cnt_r   <= '0;
      max_r   <= lwbc_pkg::CFG_W'(16);
      for (int i = 0; i < NUM_SLOTS; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
      if (cmd.touch) begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (valid_r[i] && rank_r[i] < hit_rank) begin
            rank_r[i] <= rank_r[i] + SL_W'(1);
          end
        end
        rank_r[hit_idx_r] <= '0;
      end
      if (cmd.drop_clean) begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (valid_r[i] && rank_r[i] > drop_rank) begin
            rank_r[i] <= rank_r[i] - SL_W'(1);
          end
        end
        valid_r[clean_idx_r] <= 1'b0;
        dirty_r[clean_idx_r] <= 1'b0;
        rank_r[clean_idx_r]  <= '0;
        cnt_r                <= cnt_r - CNT_W'(1);
      end
      if (cmd.alloc) begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (valid_r[i]) begin
            rank_r[i] <= rank_r[i] + SL_W'(1);
          end
        end
        valid_r[alloc_idx] <= 1'b1;
        dirty_r[alloc_idx] <= 1'b0;
        rank_r[alloc_idx]  <= '0;
        cnt_r              <= cnt_r + CNT_W'(1);
      end
      if (cmd.wr_byte) begin
        dirty_r[hit_idx_r] <= 1'b1;
      end
      if (cmd.clr_dirty) begin
        dirty_r[hit_idx_r] <= 1'b0;
      end
    end
  end

  // lookup result, slot scan, clear counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r         <= 1'b0;
      scan_idx_r    <= '0;
      free_found_r  <= 1'b0;
      clean_found_r <= 1'b0;
      clr_cnt_r     <= '0;
    end else begin
      if (cmd.lookup) begin
        hit_r     <= match_any;
        hit_idx_r <= match_idx;
      end
      if (cmd.alloc) begin
        hit_idx_r <= alloc_idx;
        clr_cnt_r <= '0;
      end
      if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + OFF_W'(1);
      end
      if (cmd.scan_clr) begin
        scan_idx_r    <= '0;
        free_found_r  <= 1'b0;
        clean_found_r <= 1'b0;
      end else if (cmd.scan_step) begin
        scan_idx_r <= scan_idx_r + SL_W'(1);
        if (!valid_r[scan_idx_r] && !free_found_r) begin
          free_found_r <= 1'b1;
          free_idx_r   <= scan_idx_r;
        end
        // strictly older wins, so the lowest index among equals stays
        if (valid_r[scan_idx_r] && !dirty_r[scan_idx_r] &&
            (!clean_found_r || rank_r[scan_idx_r] > clean_rank_r)) begin
          clean_found_r <= 1'b1;
          clean_idx_r   <= scan_idx_r;
          clean_rank_r  <= rank_r[scan_idx_r];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      res_status_r <= lwbc_pkg::ST_OK;
      res_rbyte_r  <= '0;
      res_dflag_r  <= 1'b0;
    end
    if (cmd.res_miss) begin
      res_status_r <= lwbc_pkg::ST_MISS;
    end
    if (cmd.res_full) begin
      res_status_r <= lwbc_pkg::ST_FULL;
    end
    if (cmd.res_flag) begin
      res_dflag_r <= dirty_r[hit_idx_r];
    end
    if (cmd.res_rdata) begin
      res_rbyte_r <= ram_q;
    end
    if (cmd.out_load) begin
      out_status <= res_status_r;
      out_rbyte  <= res_rbyte_r;
      out_dflag  <= res_dflag_r;
      out_count  <= cnt_r;
    end
  end

  lwbc_ram #(
    .WIDTH (lwbc_pkg::BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.clr_step | cmd.wr_byte),
    .waddr ({hit_idx_r, (cmd.clr_step ? clr_cnt_r : off)}),
    .wdata (cmd.clr_step ? '0 : wbyte_r),
    .re    (cmd.rd_issue),
    .raddr ({hit_idx_r, off}),
    .rdata (ram_q)
  );

  always_comb begin
    stat.func        = func_r;
    stat.last        = last_r;
    stat.hit         = hit_r;
    stat.free_found  = free_found_r;
    stat.clean_found = clean_found_r;
    stat.scan_last   = (scan_idx_r == SL_W'(NUM_SLOTS - 1));
    stat.clr_last    = (clr_cnt_r == OFF_W'(BLOCK_BYTES - 1));
    stat.over_max    = (MW'(cnt_r) > MW'(max_r));
  end

endmodule

// ----- rtl/core/lru_writeback_block_cache.sv -----
// Top level of the fully associative LRU write-back block cache.
// Depends on lwbc_pkg, lwbc_ctrl, lwbc_dp (with lwbc_ram) and assert_macros.svh.
//
//  channel | direction | tdata (low bit up)                         | tuser | tlast
//  in_     | input     | byte_address, write_byte, block_number     | func  | last_byte
//  out_    | output    | status, read_byte, dirty_flag, blocks_in_use | -   | -
//  cfg_    | input     | max_blocks (cfg_we / cfg_wdata)             | -     | -
//
// One transaction at a time. Query, clear and read miss go through lookup and dispatch,
// read hits add a read capture and write hits a byte write and a trim check; all end
// by loading the output register. A write miss adds a slot scan and decision, a zero
// fill of the new block (one RAM write per byte) and an allocation step if a clean
// block is evicted; each trim eviction on last_byte adds a slot scan and decision.
// Reset clears the slot table only; no clearing pass is needed. A stalled
// output holds the finished transaction while the next one is taken.
`include "assert_macros.svh"

module lru_writeback_block_cache #(
  parameter int BLOCK_BYTES = 4096,
  parameter int NUM_SLOTS   = 16,
  parameter int ADDR_BITS   = 48
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // byte_address, write_byte, block_number
  input  logic [((ADDR_BITS + 44 + 7) / 8) * 8 - 1:0] in_tdata,
  // func
  input  logic [1:0] in_tuser,
  input  logic in_tlast,
  output logic out_tvalid,
  input  logic out_tready,
  // status, read_byte, dirty_flag, blocks_in_use
  output logic [((11 + $clog2(NUM_SLOTS + 1) + 7) / 8) * 8 - 1:0] out_tdata,
  input  logic cfg_we,
  input  logic [lwbc_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int OUT_W = ((11 + CNT_W + 7) / 8) * 8;

  lwbc_pkg::cmd_t  cmd;
  lwbc_pkg::stat_t stat;

  logic [lwbc_pkg::STATUS_W-1:0] out_status;
  logic [lwbc_pkg::BYTE_W-1:0]   out_rbyte;
  logic                          out_dflag;
  logic [CNT_W-1:0]              out_count;

  lwbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  lwbc_dp #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .NUM_SLOTS   (NUM_SLOTS),
    .ADDR_BITS   (ADDR_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_func    (in_tuser),
    .in_addr    (in_tdata[ADDR_BITS-1:0]),
    .in_wbyte   (in_tdata[ADDR_BITS +: lwbc_pkg::BYTE_W]),
    .in_last    (in_tlast),
    .in_bnum    (in_tdata[ADDR_BITS + lwbc_pkg::BYTE_W +: lwbc_pkg::BLKNUM_W]),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_status (out_status),
    .out_rbyte  (out_rbyte),
    .out_dflag  (out_dflag),
    .out_count  (out_count)
  );

  assign out_tdata = OUT_W'({out_count, out_dflag, out_rbyte, out_status});

  `LWBC_ASSERT(a_busy_after_accept, (in_tvalid && in_tready) |=> !in_tready, "accepted while busy")
  `LWBC_NEVER(a_drop_alloc, cmd.drop_clean && cmd.alloc, "evict and allocate in one cycle")
  `LWBC_ASSERT(a_count_bound, out_tvalid |-> (out_count <= CNT_W'(NUM_SLOTS)), "count above slots")
  `LWBC_ASSERT(a_miss_zero, (out_tvalid && out_status == lwbc_pkg::ST_MISS) |-> (out_rbyte == '0), "miss with data")

endmodule
